FILE: rtl/rawc_pkg.sv
package rawc_pkg;

  // field widths
  localparam int OFFSET_W = 40;
  localparam int LEN_W    = OFFSET_W + 1;
  localparam int BYTES_W  = 24;
  localparam int INDEX_W  = 18;
  localparam int CMD_W    = 2;
  localparam int SEL_W    = 4;
  localparam int ACTION_W = 3;
  localparam int BUCKET_W = 3;
  localparam int CONT_W   = 2;
  localparam int COUNT_W  = 64;

  // defaults for the top level parameters
  localparam int unsigned WIN_SIZE_DEF     = 262144;
  localparam int unsigned SECTOR_BYTES_DEF = 2048;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DISC_LENGTH    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_PRESENT = 1'd1;

  // stream packing
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 152;
  localparam int S_USED_W = OFFSET_W + BYTES_W + 1 + SEL_W;
  localparam int M_USED_W = OFFSET_W + BYTES_W + INDEX_W + BUCKET_W + CONT_W + COUNT_W;

  // commands
  localparam logic [CMD_W-1:0] CMD_READ     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FILL_END = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COUNTER  = 2'd2;

  // result actions
  localparam logic [ACTION_W-1:0] ACT_IGNORED     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_HIT_COPY    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FILL        = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DIRECT      = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FILL_COPY   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_FILL_DIRECT = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_COUNTER     = 3'd6;

  // continuity codes
  localparam logic [CONT_W-1:0] CONT_FIRST  = 2'd0;
  localparam logic [CONT_W-1:0] CONT_SEQ    = 2'd1;
  localparam logic [CONT_W-1:0] CONT_DISC   = 2'd2;

  // statistic counter slots
  localparam int NUM_STATS  = 14;
  localparam int ST_REQ     = 0;
  localparam int ST_BYTES   = 1;
  localparam int ST_BUCKET0 = 2;
  localparam int NUM_BUCKETS = 7;
  localparam int ST_SEQ     = 9;
  localparam int ST_DISC    = 10;
  localparam int ST_FILLS   = 11;
  localparam int ST_HITS    = 12;
  localparam int ST_DIRECT  = 13;

  // counter bank update for one processed beat
  typedef struct packed {
    logic                req;
    logic [BUCKET_W-1:0] bucket;
    logic [BYTES_W-1:0]  bytes;
    logic                seq;
    logic                disc;
    logic                fill;
    logic                hit;
    logic                direct;
  } stat_upd_t;

endpackage

FILE: rtl/rawc_stats.sv
module rawc_stats (
  input  logic                            clk,
  input  logic                            rst,
  input  rawc_pkg::stat_upd_t             upd,
  input  logic [rawc_pkg::SEL_W-1:0]      sel,
  output logic [rawc_pkg::COUNT_W-1:0]    rd_data
);
  import rawc_pkg::*;

  logic [COUNT_W-1:0] stats [NUM_STATS];
  logic [COUNT_W-1:0] step  [NUM_STATS];

  // per-counter step for this beat
  always_comb begin
    for (int i = 0; i < NUM_STATS; i++) begin
      step[i] = '0;
    end
    step[ST_REQ]    = COUNT_W'(upd.req);
    step[ST_BYTES]  = upd.req ? COUNT_W'(upd.bytes) : '0;
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      step[ST_BUCKET0 + b] = COUNT_W'(upd.req && (upd.bucket == BUCKET_W'(b)));
    end
    step[ST_SEQ]    = COUNT_W'(upd.seq);
    step[ST_DISC]   = COUNT_W'(upd.disc);
    step[ST_FILLS]  = COUNT_W'(upd.fill);
    step[ST_HITS]   = COUNT_W'(upd.hit);
    step[ST_DIRECT] = COUNT_W'(upd.direct);
  end

  // wrapping counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STATS; i++) begin
        stats[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_STATS; i++) begin
        stats[i] <= stats[i] + step[i];
      end
    end
  end

  // read port, codes past the last slot read zero
  assign rd_data = (sel < SEL_W'(NUM_STATS)) ? stats[sel] : '0;

endmodule

FILE: rtl/read_ahead_window_controller.sv
// channel    dir  signals                      contents
// s_axis     in   tdata[71:0], tuser[1:0]      read request, fill completion or counter read
// m_axis     out  tdata[151:0], tuser[2:0]     one result beat per input beat
// cfg        in   cfg_we, cfg_index, cfg_data  disc_length, buffer_present
//
// Every input beat passes through the input register, then the decision logic and counter
// bank update into the result register. One beat is accepted every cycle while m_axis is
// not stalled; the input register takes a new beat when it is empty or when its own beat
// moves on to the result register in the same cycle.
// Synchronous reset clears window, pending fill, continuity and all counters;
// buffer_present resets to one, disc_length to zero.
module read_ahead_window_controller #(
  parameter int unsigned WIN_SIZE     = rawc_pkg::WIN_SIZE_DEF,
  parameter int unsigned SECTOR_BYTES = rawc_pkg::SECTOR_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rawc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rawc_pkg::LEN_W-1:0]         cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // request_offset[39:0], request_bytes[63:40], fill_ok[64], counter_select[68:65]
  input  logic [rawc_pkg::S_DATA_W-1:0]      s_axis_tdata,
  // command[1:0]
  input  logic [rawc_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // reader_offset[39:0], reader_bytes[63:40], window_index[81:64],
  // size_bucket[84:82], continuity[86:85], counter_value[150:87]
  output logic [rawc_pkg::M_DATA_W-1:0]      m_axis_tdata,
  // action[2:0]
  output logic [rawc_pkg::ACTION_W-1:0]      m_axis_tuser
);
  import rawc_pkg::*;

  localparam int WLEN_W = $clog2(WIN_SIZE + 1);
  localparam logic [LEN_W-1:0]  WIN_L = LEN_W'(WIN_SIZE);
  localparam logic [WLEN_W-1:0] WIN_W = WLEN_W'(WIN_SIZE);

  // configuration registers
  logic [LEN_W-1:0] disc_length;
  logic             buffer_present;

  // window state
  logic                window_valid;
  logic [OFFSET_W-1:0] window_start;
  logic [WLEN_W-1:0]   window_length;
  logic                fill_pending;
  logic [OFFSET_W-1:0] pending_offset;
  logic [BYTES_W-1:0]  pending_bytes;
  logic [WLEN_W-1:0]   pending_window;
  logic                previous_known;
  logic [LEN_W-1:0]    last_end;

  // input register
  logic                in_valid;
  logic [CMD_W-1:0]    in_cmd;
  logic [OFFSET_W-1:0] in_off;
  logic [BYTES_W-1:0]  in_n;
  logic                in_ok;
  logic [SEL_W-1:0]    in_sel;

  logic advance;

  // decision signals
  logic                is_req;
  logic                is_done;
  logic [BUCKET_W-1:0] bucket;
  logic [LEN_W-1:0]    off_ext;
  logic [LEN_W-1:0]    n_ext;
  logic [LEN_W-1:0]    end_sum;
  logic                seq;
  logic                direct_early;
  logic [OFFSET_W-1:0] win_pos;
  logic [WLEN_W-1:0]   win_left;
  logic                win_hit;
  logic [LEN_W-1:0]    remaining;
  logic [WLEN_W-1:0]   fill_size;
  logic                direct_late;

  // result fields
  logic [ACTION_W-1:0] act;
  logic [OFFSET_W-1:0] r_off;
  logic [BYTES_W-1:0]  r_bytes;
  logic [INDEX_W-1:0]  w_idx;
  logic [BUCKET_W-1:0] r_bucket;
  logic [CONT_W-1:0]   cont;
  logic [COUNT_W-1:0]  cval;

  stat_upd_t upd;

  // counter bank read data
  logic [COUNT_W-1:0] stat_rd;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      disc_length    <= '0;
      buffer_present <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISC_LENGTH:    disc_length    <= cfg_data;
        REG_BUFFER_PRESENT: buffer_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd <= s_axis_tuser;
      in_off <= s_axis_tdata[OFFSET_W-1:0];
      in_n   <= s_axis_tdata[OFFSET_W +: BYTES_W];
      in_ok  <= s_axis_tdata[OFFSET_W + BYTES_W];
      in_sel <= s_axis_tdata[OFFSET_W + BYTES_W + 1 +: SEL_W];
    end
  end

  // request size class
  always_comb begin
    bucket = BUCKET_W'(NUM_BUCKETS - 1);
    for (int k = NUM_BUCKETS - 2; k >= 0; k--) begin
      if ({1'b0, in_n} <= (BYTES_W + 1)'(SECTOR_BYTES << k)) begin
        bucket = BUCKET_W'(k);
      end
    end
  end

  // window and disc checks
  assign is_req  = (in_cmd == CMD_READ) && (in_n != '0);
  assign is_done = (in_cmd == CMD_FILL_END) && fill_pending;
  assign off_ext = LEN_W'(in_off);
  assign n_ext   = LEN_W'(in_n);
  assign end_sum = off_ext + n_ext;
  assign seq     = (off_ext == last_end);

  assign direct_early = (off_ext >= disc_length) || !buffer_present || (n_ext > WIN_L);

  assign win_pos  = in_off - window_start;
  assign win_left = window_length - win_pos[WLEN_W-1:0];
  assign win_hit  = window_valid && (in_off >= window_start)
                    && (win_pos <= OFFSET_W'(window_length))
                    && (n_ext <= LEN_W'(win_left));

  assign remaining   = disc_length - off_ext;
  assign fill_size   = (remaining < WIN_L) ? remaining[WLEN_W-1:0] : WIN_W;
  assign direct_late = n_ext > LEN_W'(fill_size);

  // result and counter update selection
  always_comb begin
    act      = ACT_IGNORED;
    r_off    = '0;
    r_bytes  = '0;
    w_idx    = '0;
    r_bucket = '0;
    cont     = CONT_FIRST;
    cval     = '0;
    upd      = '0;
    if (is_req) begin
      upd.req    = 1'b1;
      upd.bucket = bucket;
      upd.bytes  = in_n;
      r_bucket   = bucket;
      if (previous_known) begin
        upd.seq  = seq;
        upd.disc = !seq;
        cont     = seq ? CONT_SEQ : CONT_DISC;
      end
      if (direct_early) begin
        upd.direct = 1'b1;
        act        = ACT_DIRECT;
        r_off      = in_off;
        r_bytes    = in_n;
      end else if (win_hit) begin
        upd.hit = 1'b1;
        act     = ACT_HIT_COPY;
        r_bytes = in_n;
        w_idx   = INDEX_W'(win_pos);
      end else if (direct_late) begin
        upd.direct = 1'b1;
        act        = ACT_DIRECT;
        r_off      = in_off;
        r_bytes    = in_n;
      end else begin
        act     = ACT_FILL;
        r_off   = in_off;
        r_bytes = BYTES_W'(fill_size);
      end
    end else if (is_done) begin
      if (in_ok) begin
        upd.fill = 1'b1;
        act      = ACT_FILL_COPY;
        r_bytes  = pending_bytes;
      end else begin
        upd.direct = 1'b1;
        act        = ACT_FILL_DIRECT;
        r_off      = pending_offset;
        r_bytes    = pending_bytes;
      end
    end else if (in_cmd == CMD_COUNTER) begin
      act  = ACT_COUNTER;
      cval = stat_rd;
    end
    if (!advance) begin
      upd = '0;
    end
  end

  // counter bank
  rawc_stats u_stats (
    .clk     (clk),
    .rst     (rst),
    .upd     (upd),
    .sel     (in_sel),
    .rd_data (stat_rd)
  );

  // window control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_valid   <= 1'b0;
      fill_pending   <= 1'b0;
      previous_known <= 1'b0;
    end else if (advance) begin
      if (is_req) begin
        previous_known <= 1'b1;
        if (act == ACT_FILL) begin
          window_valid <= 1'b0;
          fill_pending <= 1'b1;
        end
      end else if (is_done) begin
        fill_pending <= 1'b0;
        if (in_ok) begin
          window_valid <= 1'b1;
        end
      end
    end
  end

  // window payload state
  always_ff @(posedge clk) begin
    if (advance) begin
      if (is_req) begin
        last_end <= end_sum;
        if (act == ACT_FILL) begin
          pending_offset <= in_off;
          pending_bytes  <= in_n;
          pending_window <= fill_size;
        end
      end else if (is_done && in_ok) begin
        window_start  <= pending_offset;
        window_length <= pending_window;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tuser <= act;
      m_axis_tdata <= {{(M_DATA_W - M_USED_W){1'b0}},
                       cval, cont, r_bucket, w_idx, r_bytes, r_off};
    end
  end

endmodule
